FILE: rtl/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

    // operation codes
    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // response status codes
    localparam logic [1:0] ST_FOUND    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_MISSING  = 2'd3;

    // response payload select
    localparam logic [1:0] PAY_ZERO = 2'd0;
    localparam logic [1:0] PAY_MEM  = 2'd1;
    localparam logic [1:0] PAY_DEF  = 2'd2;

    localparam int KEY_W  = 32;
    localparam int DISP_W = 64;
    localparam int TYPE_W = 32;

    typedef struct packed {
        logic signed [DISP_W-1:0] disp;
        logic [TYPE_W-1:0]        elem_type;
        logic [TYPE_W-1:0]        file_type;
    } val_t;

    // controller -> datapath
    typedef struct packed {
        logic       in_ready;
        logic       scan;
        logic       val_read;
        logic       write_hit;
        logic       write_new;
        logic       load_out;
        logic [1:0] out_status;
        logic [1:0] pay_sel;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic accept;
        logic op;
        logic match;
        logic scan_done;
        logic full;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

FILE: rtl/kvt_if.sv
`default_nettype none

interface kvt_req_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   operation;
    logic [15:0]                            client_key;
    logic [15:0]                            file_key;
    logic signed [kvt_pkg::DISP_W-1:0]      in_displacement;
    logic [kvt_pkg::TYPE_W-1:0]             in_element_type;
    logic [kvt_pkg::TYPE_W-1:0]             in_file_type;

    modport source (
        output valid, operation, client_key, file_key,
               in_displacement, in_element_type, in_file_type,
        input  ready
    );
    modport sink (
        input  valid, operation, client_key, file_key,
               in_displacement, in_element_type, in_file_type,
        output ready
    );
endinterface

interface kvt_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             status;
    logic signed [kvt_pkg::DISP_W-1:0]      out_displacement;
    logic [kvt_pkg::TYPE_W-1:0]             out_element_type;
    logic [kvt_pkg::TYPE_W-1:0]             out_file_type;

    modport source (
        output valid, status, out_displacement, out_element_type, out_file_type,
        input  ready
    );
    modport sink (
        input  valid, status, out_displacement, out_element_type, out_file_type,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/kvt_datapath.sv
`default_nettype none

module kvt_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [kvt_pkg::TYPE_W-1:0]    cfg_wdata,
    kvt_req_if.sink                            req,
    kvt_rsp_if.source                          rsp,
    input  wire kvt_pkg::cmd_t                 cmd,
    output kvt_pkg::sts_t                      sts
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // key and value stores
    logic [kvt_pkg::KEY_W-1:0] key_mem [TABLE_DEPTH];
    kvt_pkg::val_t             val_mem [TABLE_DEPTH];

    logic [kvt_pkg::TYPE_W-1:0] def_type_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           scan_idx_reg;
    logic                       cmp_valid_reg;
    logic [IDX_W-1:0]           cmp_idx_reg;
    logic [kvt_pkg::KEY_W-1:0]  key_rd_reg;
    logic [IDX_W-1:0]           slot_reg;
    kvt_pkg::val_t              val_rd_reg;

    // captured request
    logic                       req_op_reg;
    logic [kvt_pkg::KEY_W-1:0]  req_key_reg;
    kvt_pkg::val_t              req_val_reg;

    // response register
    logic                       out_valid_reg;
    logic [1:0]                 out_status_reg;
    kvt_pkg::val_t              out_val_reg;

    logic                       accept;
    logic                       scan_rd;
    logic                       match;
    logic                       full;
    logic                       out_take;
    kvt_pkg::val_t              out_val_next;

    assign accept   = req.valid && cmd.in_ready;
    assign scan_rd  = cmd.scan && (scan_idx_reg < cnt_reg);
    assign match    = cmp_valid_reg && (key_rd_reg == req_key_reg);
    assign full     = (cnt_reg == CNT_W'(TABLE_DEPTH));
    assign out_take = out_valid_reg && rsp.ready;

    assign req.ready = cmd.in_ready;

    assign sts.accept    = accept;
    assign sts.op        = req_op_reg;
    assign sts.match     = match;
    assign sts.scan_done = !cmp_valid_reg && (scan_idx_reg == cnt_reg);
    assign sts.full      = full;
    assign sts.out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.out_displacement = out_val_reg.disp;
    assign rsp.out_element_type = out_val_reg.elem_type;
    assign rsp.out_file_type    = out_val_reg.file_type;

    always_comb
    begin
        case (cmd.pay_sel)
            kvt_pkg::PAY_MEM:
            begin
                out_val_next = val_rd_reg;
            end
            kvt_pkg::PAY_DEF:
            begin
                out_val_next.disp      = '0;
                out_val_next.elem_type = def_type_reg;
                out_val_next.file_type = def_type_reg;
            end
            default:
            begin
                out_val_next = '0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            def_type_reg  <= '0;
            cnt_reg       <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                def_type_reg <= cfg_wdata;
            end
            if (accept)
            begin
                scan_idx_reg  <= '0;
                cmp_valid_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                cmp_valid_reg <= scan_rd;
                if (scan_rd)
                begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
            end
            if (cmd.write_new)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_op_reg            <= req.operation;
            req_key_reg           <= {req.client_key, req.file_key};
            req_val_reg.disp      <= req.in_displacement;
            req_val_reg.elem_type <= req.in_element_type;
            req_val_reg.file_type <= req.in_file_type;
        end
        if (scan_rd)
        begin
            cmp_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (cmd.scan && match)
        begin
            slot_reg <= cmp_idx_reg;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.out_status;
            out_val_reg    <= out_val_next;
        end
    end

    // memories: one read and one write port each
    always_ff @(posedge clk)
    begin
        if (scan_rd)
        begin
            key_rd_reg <= key_mem[scan_idx_reg[IDX_W-1:0]];
        end
        if (cmd.write_new)
        begin
            key_mem[cnt_reg[IDX_W-1:0]] <= req_key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.val_read)
        begin
            val_rd_reg <= val_mem[slot_reg];
        end
        if (cmd.write_new)
        begin
            val_mem[cnt_reg[IDX_W-1:0]] <= req_val_reg;
        end
        else if (cmd.write_hit)
        begin
            val_mem[slot_reg] <= req_val_reg;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_no_append_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |-> !full)
        else $error("append while table full");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("fill count did not advance on append");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || rsp.ready))
        else $error("response register overwritten");

    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> ({1'b0, cmp_idx_reg} < (IDX_W+1)'(cnt_reg)))
        else $error("compare on unfilled entry");

endmodule

`default_nettype wire

FILE: rtl/kvt_ctrl.sv
`default_nettype none

module kvt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire kvt_pkg::sts_t  sts,
    output kvt_pkg::cmd_t       cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.match)
                begin
                    status_next = kvt_pkg::ST_FOUND;
                    state_next  = (sts.op == kvt_pkg::OP_LOOKUP) ? S_READ : S_RESP;
                end
                else if (sts.scan_done)
                begin
                    state_next = S_RESP;
                    if (sts.op == kvt_pkg::OP_LOOKUP)
                    begin
                        status_next = kvt_pkg::ST_MISSING;
                    end
                    else if (sts.full)
                    begin
                        status_next = kvt_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next = kvt_pkg::ST_INSERTED;
                    end
                end
            end
            S_READ:
            begin
                cmd.val_read = 1'b1;
                state_next   = S_RESP;
            end
            S_RESP:
            begin
                cmd.out_status = status_reg;
                if (sts.op == kvt_pkg::OP_LOOKUP && status_reg == kvt_pkg::ST_FOUND)
                begin
                    cmd.pay_sel = kvt_pkg::PAY_MEM;
                end
                else if (status_reg == kvt_pkg::ST_MISSING)
                begin
                    cmd.pay_sel = kvt_pkg::PAY_DEF;
                end
                else
                begin
                    cmd.pay_sel = kvt_pkg::PAY_ZERO;
                end
                if (sts.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.write_hit = (sts.op == kvt_pkg::OP_STORE) &&
                                    (status_reg == kvt_pkg::ST_FOUND);
                    cmd.write_new = (status_reg == kvt_pkg::ST_INSERTED);
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= kvt_pkg::ST_FOUND;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sts.accept |-> state_reg == S_IDLE)
        else $error("request taken outside idle");

    a_read_then_resp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_RESP)
        else $error("value read not followed by response");

    a_write_one: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write_hit && cmd.write_new))
        else $error("update and append together");

endmodule

`default_nettype wire

FILE: rtl/keyed_view_table_core.sv
// Requests are handled one at a time: a new request is taken only in idle, once the
//   previous one has been loaded into the response register. The key scan stops at the
//   first matching entry or after the last filled one, and a lookup hit adds a value read;
//   the scan reads one entry per cycle through the key memory's single read port.
// Reset (rst_n, asynchronous, active low) empties the table and clears the default
//   type handle; entry storage is not cleared, as only filled entries are ever read.
`default_nettype none

module keyed_view_table_core #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [kvt_pkg::TYPE_W-1:0] cfg_wdata,
    kvt_req_if.sink                         req,
    kvt_rsp_if.source                       rsp
);

    // Command and status between sequencer and datapath.
    kvt_pkg::cmd_t cmd;
    kvt_pkg::sts_t sts;

    // Sequencer: idle -> scan -> (value read on a lookup hit) -> respond.
    // The response stage only proceeds once the response register is free,
    // so a waiting response holds the table writes of that request back.
    kvt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Datapath: key and value memories, fill count, the pipelined key scan
    // (read one entry, compare the next cycle), default handle register and
    // the response register that decouples the output side.
    kvt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
